// ===== rtl/bdc_pkg.sv =====
// Shared types and constants of the battery discharge controller.
// Used by the controller, the datapath, the top level and the testbench.
`default_nettype none

package bdc_pkg;

   // Command codes carried by a request
   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_PAUSE  = 2'd2,
      CMD_KNOB   = 2'd3
   } bdc_cmd_type;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIRE_RES    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_VOLTAGE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_TARGET = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERCURRENT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_CAP   = 3'd4;

   // Current range and end cause codes
   localparam logic [1:0] RANGE_HIGH    = 2'd0;
   localparam logic [1:0] RANGE_MEDIUM  = 2'd1;
   localparam logic [1:0] RANGE_LOW     = 2'd2;
   localparam logic [1:0] CAUSE_NONE    = 2'd0;
   localparam logic [1:0] CAUSE_VOLTAGE = 2'd1;
   localparam logic [1:0] CAUSE_CURRENT = 2'd2;

   // Shared multiplier
   localparam int MUL_W  = 23;
   localparam int PROD_W = 2 * MUL_W;

   // Reciprocals for exact floor division: floor(x/D) = (x*M) >> K
   localparam int K_DROP = 32;    // x < 2**22, D = 1000
   localparam logic [MUL_W-1:0] M_DROP = MUL_W'(((64'd1 << K_DROP) / 64'd1000) + 64'd1);
   localparam int K_CAP = 19;     // x < 2**12, D = 100
   localparam logic [MUL_W-1:0] M_CAP = MUL_W'(((64'd1 << K_CAP) / 64'd100) + 64'd1);
   localparam int K_GATE = 27;    // x < 2**20, D = 100
   localparam logic [MUL_W-1:0] M_GATE = MUL_W'(((64'd1 << K_GATE) / 64'd100) + 64'd1);

   // Datapath operations, one per controller step
   typedef enum logic [4:0] {
      OP_NONE,
      OP_START,
      OP_RESYNC,
      OP_PAUSE,
      OP_KNOB,
      OP_FILL_INIT,
      OP_FILL,
      OP_READ,
      OP_WRITE,
      OP_MUL_VAVG,
      OP_MUL_IAVG,
      OP_MUL_DROP,
      OP_MUL_DROPDIV,
      OP_AVG_CHARGE,
      OP_EVAL,
      OP_RT_CAP,
      OP_RT_SETP,
      OP_RT_GK,
      OP_RT_GDIV,
      OP_RT_GATE,
      OP_EMIT
   } bdc_op_type;

   // Controller to datapath
   typedef struct packed {
      bdc_op_type op;
      logic       take;     // request accepted this cycle
   } bdc_ctl_type;

   // Datapath to controller
   typedef struct packed {
      bdc_cmd_type cmd;
      logic        ended;
      logic        resync_busy;
      logic        paused;
      logic        empty;
      logic        pos_last;
      logic        step_due;
      logic        knob_changed;
      logic        out_free;
   } bdc_status_type;

endpackage

`default_nettype wire

// ===== rtl/bdc_if.sv =====
// Request and response channel interfaces of the battery discharge controller.
// Depends on bdc_pkg for nothing but shares its naming; valid/ready handshake.
`default_nettype none

interface bdc_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [12:0]       voltage_mv;
   logic [11:0]       current_ma;
   logic              refresh_due;
   logic signed [1:0] knob_direction;

   modport source (output valid, cmd, voltage_mv, current_ma, refresh_due,
                   knob_direction, input ready);
   modport sink   (input valid, cmd, voltage_mv, current_ma, refresh_due,
                   knob_direction, output ready);
endinterface

interface bdc_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] gate_code;
   logic        is_paused;
   logic [1:0]  current_range;
   logic        finished;
   logic [1:0]  end_cause;
   logic [13:0] avg_voltage_mv;
   logic [11:0] avg_current_ma;
   logic [31:0] charge_sum;
   logic [11:0] setpoint_ma;

   modport source (output valid, gate_code, is_paused, current_range, finished,
                   end_cause, avg_voltage_mv, avg_current_ma, charge_sum,
                   setpoint_ma, input ready);
   modport sink   (input valid, gate_code, is_paused, current_range, finished,
                   end_cause, avg_voltage_mv, avg_current_ma, charge_sum,
                   setpoint_ma, output ready);
endinterface

`default_nettype wire

// ===== rtl/battery_discharge_controller.sv =====
// Top level of the constant-current battery discharge controller.
// Depends on bdc_pkg, bdc_if (channels), bdc_ctrl and bdc_dp.
//
// One response per request, in order. Requests are taken one at a time; a
// request is accepted while the previous response still waits in the output
// register. The sequencer steps a single shared multiplier for each request:
// a start or any retarget (unpause, knob change) runs the retarget steps,
// pause/resync/ignored requests run none of them, and a sample runs the
// averaging steps, first refilling the window from the first sample when it
// was cleared, and then the retarget steps when it steps the current range
// down. Divisions by constants are reciprocal multiplies on that same
// multiplier. There is no clearing pass after reset.
`default_nettype none

module battery_discharge_controller
   import bdc_pkg::*;
#(
   parameter int AVG_SAMPLES     = 8,   // averaging window depth, 1 to 64
   parameter int REFRESH_SECONDS = 5    // seconds per refresh tick, 1 to 60
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   bdc_req_if.sink                     req_bus,
   bdc_rsp_if.source                   rsp_bus,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   bdc_ctl_type    ctl;
   bdc_status_type status;
   logic           req_ready;

   // sequencer: owns the request handshake and steps the datapath
   bdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .ctl       (ctl)
   );

   assign req_bus.ready = req_ready;

   // datapath: latches the request, holds the response until taken
   bdc_dp #(
      .AVG_SAMPLES     (AVG_SAMPLES),
      .REFRESH_SECONDS (REFRESH_SECONDS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .status             (status),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_cmd            (req_bus.cmd),
      .req_voltage_mv     (req_bus.voltage_mv),
      .req_current_ma     (req_bus.current_ma),
      .req_refresh_due    (req_bus.refresh_due),
      .req_knob_direction (req_bus.knob_direction),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_gate_code      (rsp_bus.gate_code),
      .rsp_is_paused      (rsp_bus.is_paused),
      .rsp_current_range  (rsp_bus.current_range),
      .rsp_finished       (rsp_bus.finished),
      .rsp_end_cause      (rsp_bus.end_cause),
      .rsp_avg_voltage_mv (rsp_bus.avg_voltage_mv),
      .rsp_avg_current_ma (rsp_bus.avg_current_ma),
      .rsp_charge_sum     (rsp_bus.charge_sum),
      .rsp_setpoint_ma    (rsp_bus.setpoint_ma)
   );

endmodule

`default_nettype wire

// ===== rtl/bdc_ctrl.sv =====
// Battery discharge controller sequencer, using bdc_pkg op/status types:
// one datapath operation per cycle, stalling while the response is full.
`default_nettype none

module bdc_ctrl
   import bdc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire bdc_status_type status,
   output bdc_ctl_type         ctl
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_START,
      ST_RESYNC,
      ST_PAUSE,
      ST_KNOB,
      ST_FILL_INIT,
      ST_FILL,
      ST_READ,
      ST_WRITE,
      ST_MUL_VAVG,
      ST_MUL_IAVG,
      ST_MUL_DROP,
      ST_MUL_DROPDIV,
      ST_AVG_CHARGE,
      ST_EVAL,
      ST_RT_CAP,
      ST_RT_SETP,
      ST_RT_GK,
      ST_RT_GDIV,
      ST_RT_GATE,
      ST_DONE,
      ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   bdc_op_type op_ff;

   function automatic bdc_op_type op_of(input state_type s);
      bdc_op_type o;
      unique case (s)
         ST_START:       o = OP_START;
         ST_RESYNC:      o = OP_RESYNC;
         ST_PAUSE:       o = OP_PAUSE;
         ST_KNOB:        o = OP_KNOB;
         ST_FILL_INIT:   o = OP_FILL_INIT;
         ST_FILL:        o = OP_FILL;
         ST_READ:        o = OP_READ;
         ST_WRITE:       o = OP_WRITE;
         ST_MUL_VAVG:    o = OP_MUL_VAVG;
         ST_MUL_IAVG:    o = OP_MUL_IAVG;
         ST_MUL_DROP:    o = OP_MUL_DROP;
         ST_MUL_DROPDIV: o = OP_MUL_DROPDIV;
         ST_AVG_CHARGE:  o = OP_AVG_CHARGE;
         ST_EVAL:        o = OP_EVAL;
         ST_RT_CAP:      o = OP_RT_CAP;
         ST_RT_SETP:     o = OP_RT_SETP;
         ST_RT_GK:       o = OP_RT_GK;
         ST_RT_GDIV:     o = OP_RT_GDIV;
         ST_RT_GATE:     o = OP_RT_GATE;
         ST_EMIT:        o = OP_EMIT;
         default:        o = OP_NONE;
      endcase
      return o;
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign ctl.take  = req_valid && (state_ff == ST_IDLE);
   assign ctl.op    = op_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (status.cmd == CMD_START) state_in = ST_START;
            else if (status.ended) state_in = ST_DONE;
            else begin
               unique case (status.cmd)
                  CMD_SAMPLE: begin
                     if (status.resync_busy) state_in = ST_RESYNC;
                     else if (status.paused) state_in = ST_DONE;
                     else if (status.empty) state_in = ST_FILL_INIT;
                     else state_in = ST_READ;
                  end
                  CMD_PAUSE: state_in = ST_PAUSE;
                  default:   state_in = ST_KNOB;
               endcase
            end
         end
         ST_START:       state_in = ST_RT_CAP;
         ST_RESYNC:      state_in = ST_DONE;
         ST_PAUSE:       state_in = status.paused ? ST_RT_CAP : ST_DONE;
         ST_KNOB:        state_in = status.knob_changed ? ST_RT_CAP : ST_DONE;
         ST_FILL_INIT:   state_in = ST_FILL;
         ST_FILL:        state_in = status.pos_last ? ST_READ : ST_FILL;
         ST_READ:        state_in = ST_WRITE;
         ST_WRITE:       state_in = ST_MUL_VAVG;
         ST_MUL_VAVG:    state_in = ST_MUL_IAVG;
         ST_MUL_IAVG:    state_in = ST_MUL_DROP;
         ST_MUL_DROP:    state_in = ST_MUL_DROPDIV;
         ST_MUL_DROPDIV: state_in = ST_AVG_CHARGE;
         ST_AVG_CHARGE:  state_in = ST_EVAL;
         ST_EVAL:        state_in = status.step_due ? ST_RT_CAP : ST_DONE;
         ST_RT_CAP:      state_in = ST_RT_SETP;
         ST_RT_SETP:     state_in = ST_RT_GK;
         ST_RT_GK:       state_in = ST_RT_GDIV;
         ST_RT_GDIV:     state_in = ST_RT_GATE;
         ST_RT_GATE:     state_in = ST_DONE;
         ST_DONE: begin
            if (status.out_free) state_in = ST_EMIT;
         end
         ST_EMIT:        state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_NONE;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_of(state_in);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bdc_dp.sv =====
// Datapath of the battery discharge controller: configuration registers,
// averaging window memory, shared multiplier and test state. Uses bdc_pkg.
`default_nettype none

module bdc_dp
   import bdc_pkg::*;
#(
   parameter int AVG_SAMPLES     = 8,
   parameter int REFRESH_SECONDS = 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bdc_ctl_type            ctl,
   output bdc_status_type              status,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [1:0]             req_cmd,
   input  wire logic [12:0]            req_voltage_mv,
   input  wire logic [11:0]            req_current_ma,
   input  wire logic                   req_refresh_due,
   input  wire logic signed [1:0]      req_knob_direction,
   input  wire logic                   rsp_ready,
   output logic                        rsp_valid,
   output logic [11:0]                 rsp_gate_code,
   output logic                        rsp_is_paused,
   output logic [1:0]                  rsp_current_range,
   output logic                        rsp_finished,
   output logic [1:0]                  rsp_end_cause,
   output logic [13:0]                 rsp_avg_voltage_mv,
   output logic [11:0]                 rsp_avg_current_ma,
   output logic [31:0]                 rsp_charge_sum,
   output logic [11:0]                 rsp_setpoint_ma
);

   localparam int POS_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
   localparam int SUM_W = 13 + $clog2(AVG_SAMPLES);
   localparam int K_AVG = SUM_W + $clog2(AVG_SAMPLES);
   localparam logic [MUL_W-1:0] M_AVG =
      MUL_W'(((64'd1 << K_AVG) / 64'(AVG_SAMPLES)) + 64'd1);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVG_SAMPLES - 1);
   localparam logic signed [1:0] KNOB_UP   = 2'sd1;
   localparam logic signed [1:0] KNOB_NONE = 2'sd0;

   // configuration
   logic [9:0]  wire_res_ff;
   logic [12:0] min_voltage_ff;
   logic [10:0] init_target_ff;
   logic [11:0] overcurrent_ff;
   logic [11:0] power_cap_ff;

   // latched request
   bdc_cmd_type       lat_cmd_ff;
   logic [12:0]       lat_mv_ff;
   logic [11:0]       lat_ma_ff;
   logic              lat_refresh_ff;
   logic signed [1:0] lat_kd_ff;

   // averaging window
   logic [12:0]      vwin_mem [AVG_SAMPLES];
   logic [11:0]      iwin_mem [AVG_SAMPLES];
   logic [12:0]      rd_v_ff;
   logic [11:0]      rd_i_ff;
   logic [POS_W-1:0] pos_ff;
   logic             empty_ff;
   logic [SUM_W-1:0] vsum_ff;
   logic [SUM_W-1:0] isum_ff;

   // arithmetic
   logic [MUL_W-1:0]  mul_x, mul_y;
   logic [PROD_W-1:0] mul_p;
   logic [PROD_W-1:0] prod_ff;
   logic [12:0]       vavg_ff;
   logic [13:0]       avg_v_ff;
   logic [11:0]       avg_i_ff;

   // test state
   logic [10:0] target_ff;
   logic [11:0] setpoint_ff;
   logic [11:0] gate_ff;
   logic [1:0]  range_ff;
   logic        paused_ff;
   logic [1:0]  resync_ff;
   logic [31:0] charge_ff;
   logic        ended_ff;
   logic [1:0]  cause_ff;
   logic        rsp_valid_ff;

   logic [10:0]      knob_new;
   logic             step_due;
   logic [POS_W-1:0] pos_next;
   logic [32:0]      charge_add;
   logic [31:0]      charge_sat;
   logic [11:0]      setpoint_new;
   logic [12:0]      gate_q;
   logic [13:0]      gate_raw;
   logic [11:0]      gate_new;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wire_res_ff    <= 10'd0;
         min_voltage_ff <= 13'd3000;
         init_target_ff <= 11'd500;
         overcurrent_ff <= 12'd2000;
         power_cap_ff   <= 12'd4000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WIRE_RES:    wire_res_ff    <= csr_wdata[9:0];
            CSR_MIN_VOLTAGE: min_voltage_ff <= csr_wdata[12:0];
            CSR_INIT_TARGET: init_target_ff <= csr_wdata[10:0];
            CSR_OVERCURRENT: overcurrent_ff <= csr_wdata[11:0];
            CSR_POWER_CAP:   power_cap_ff   <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // knob: raise below 1500, lower above 150
   always_comb begin
      knob_new = target_ff;
      if (lat_kd_ff == KNOB_UP) begin
         if (target_ff < 11'd1500) knob_new = target_ff + 11'd100;
      end else if (lat_kd_ff != KNOB_NONE) begin
         if (target_ff > 11'd150) knob_new = target_ff - 11'd100;
      end
   end

   // range step condition on the corrected average
   always_comb begin
      case (range_ff)
         RANGE_HIGH:
            step_due = (avg_v_ff < ((setpoint_ff > 12'd700) ? 14'd3100 : 14'd3300))
                       && (setpoint_ff > 12'd500);
         RANGE_MEDIUM:
            step_due = (avg_v_ff < 14'd3200) && (setpoint_ff > 12'd250);
         default:
            step_due = 1'b0;
      endcase
   end

   assign pos_next   = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
   assign charge_add = {1'b0, charge_ff} + {1'b0, prod_ff[31:0]};
   assign charge_sat = charge_add[32] ? 32'hFFFF_FFFF : charge_add[31:0];

   // setpoint: target, or 50 plus whole hundreds of a lower power cap
   assign setpoint_new = ({1'b0, target_ff} > power_cap_ff)
                         ? 12'(12'(prod_ff[K_CAP +: 6]) * 12'd100 + 12'd50)
                         : {1'b0, target_ff};

   // gate code, piecewise linear in the setpoint
   assign gate_q = prod_ff[K_GATE +: 13];
   always_comb begin
      if (setpoint_ff < 12'd200) gate_raw = {1'b0, setpoint_ff, 1'b0} + 14'd1440;
      else if (setpoint_ff < 12'd1100) gate_raw = {1'b0, gate_q} + 14'd1525;
      else gate_raw = {1'b0, gate_q} + 14'd1443;
      gate_new = (gate_raw > 14'd4095) ? 12'd4095 : gate_raw[11:0];
   end

   // shared multiplier operands
   always_comb begin
      mul_x = '0;
      mul_y = '0;
      case (ctl.op)
         OP_MUL_VAVG: begin
            mul_x = MUL_W'(vsum_ff);
            mul_y = M_AVG;
         end
         OP_MUL_IAVG: begin
            mul_x = MUL_W'(isum_ff);
            mul_y = M_AVG;
         end
         OP_MUL_DROP: begin
            mul_x = MUL_W'(prod_ff[K_AVG +: 12]);
            mul_y = MUL_W'(wire_res_ff);
         end
         OP_MUL_DROPDIV: begin
            mul_x = MUL_W'(prod_ff[21:0]);
            mul_y = M_DROP;
         end
         OP_AVG_CHARGE: begin
            mul_x = MUL_W'(avg_i_ff);
            mul_y = MUL_W'(REFRESH_SECONDS);
         end
         OP_RT_CAP: begin
            mul_x = MUL_W'(power_cap_ff);
            mul_y = M_CAP;
         end
         OP_RT_GK: begin
            mul_x = MUL_W'(setpoint_ff);
            mul_y = (setpoint_ff < 12'd1100) ? MUL_W'(128) : MUL_W'(138);
         end
         OP_RT_GDIV: begin
            mul_x = MUL_W'(prod_ff[19:0]);
            mul_y = M_GATE;
         end
         default: ;
      endcase
   end

   assign mul_p = {{MUL_W{1'b0}}, mul_x} * {{MUL_W{1'b0}}, mul_y};

   // window memory
   always_ff @(posedge clock) begin
      if ((ctl.op == OP_FILL) || (ctl.op == OP_WRITE)) begin
         vwin_mem[pos_ff] <= lat_mv_ff;
         iwin_mem[pos_ff] <= lat_ma_ff;
      end
      rd_v_ff <= vwin_mem[pos_ff];
      rd_i_ff <= iwin_mem[pos_ff];
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      if (ctl.take) begin
         lat_cmd_ff     <= bdc_cmd_type'(req_cmd);
         lat_mv_ff      <= req_voltage_mv;
         lat_ma_ff      <= req_current_ma;
         lat_refresh_ff <= req_refresh_due;
         lat_kd_ff      <= req_knob_direction;
         avg_v_ff       <= '0;
         avg_i_ff       <= '0;
      end
      case (ctl.op)
         OP_FILL_INIT: begin
            vsum_ff <= '0;
            isum_ff <= '0;
         end
         OP_FILL: begin
            vsum_ff <= vsum_ff + SUM_W'(lat_mv_ff);
            isum_ff <= isum_ff + SUM_W'(lat_ma_ff);
         end
         OP_WRITE: begin
            vsum_ff <= vsum_ff + SUM_W'(lat_mv_ff) - SUM_W'(rd_v_ff);
            isum_ff <= isum_ff + SUM_W'(lat_ma_ff) - SUM_W'(rd_i_ff);
         end
         OP_MUL_IAVG:   vavg_ff  <= prod_ff[K_AVG +: 13];
         OP_MUL_DROP:   avg_i_ff <= prod_ff[K_AVG +: 12];
         OP_AVG_CHARGE: avg_v_ff <= {1'b0, vavg_ff} + {1'b0, prod_ff[K_DROP +: 13]};
         OP_EMIT: begin
            rsp_gate_code      <= (paused_ff || ended_ff) ? 12'd0 : gate_ff;
            rsp_is_paused      <= paused_ff;
            rsp_current_range  <= range_ff;
            rsp_finished       <= ended_ff;
            rsp_end_cause      <= cause_ff;
            rsp_avg_voltage_mv <= avg_v_ff;
            rsp_avg_current_ma <= avg_i_ff;
            rsp_charge_sum     <= charge_ff;
            rsp_setpoint_ma    <= setpoint_ff;
         end
         default: ;
      endcase
   end

   // test state
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         setpoint_ff  <= '0;
         gate_ff      <= '0;
         range_ff     <= RANGE_HIGH;
         paused_ff    <= 1'b0;
         resync_ff    <= '0;
         charge_ff    <= '0;
         ended_ff     <= 1'b0;
         cause_ff     <= CAUSE_NONE;
         pos_ff       <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.op == OP_EMIT) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         case (ctl.op)
            OP_START: begin
               charge_ff <= '0;
               paused_ff <= 1'b0;
               ended_ff  <= 1'b0;
               cause_ff  <= CAUSE_NONE;
               target_ff <= init_target_ff;
               range_ff  <= RANGE_HIGH;
               empty_ff  <= 1'b1;
            end
            OP_RESYNC:    resync_ff <= resync_ff - 2'd1;
            OP_PAUSE:     paused_ff <= !paused_ff;
            OP_KNOB:      target_ff <= knob_new;
            OP_FILL_INIT: pos_ff    <= '0;
            OP_FILL:      pos_ff    <= pos_next;
            OP_WRITE: begin
               pos_ff   <= pos_next;
               empty_ff <= 1'b0;
            end
            OP_EVAL: begin
               if (step_due) begin
                  if (range_ff == RANGE_HIGH) begin
                     target_ff <= 11'd500;
                     range_ff  <= RANGE_MEDIUM;
                  end else begin
                     target_ff <= 11'd250;
                     range_ff  <= RANGE_LOW;
                  end
               end else if (avg_v_ff < {1'b0, min_voltage_ff}) begin
                  ended_ff <= 1'b1;
                  cause_ff <= CAUSE_VOLTAGE;
               end else if (lat_ma_ff > overcurrent_ff) begin
                  ended_ff <= 1'b1;
                  cause_ff <= CAUSE_CURRENT;
               end else if (lat_refresh_ff) begin
                  charge_ff <= charge_sat;
               end
            end
            OP_RT_SETP: begin
               setpoint_ff <= setpoint_new;
               empty_ff    <= 1'b1;
               resync_ff   <= (lat_cmd_ff == CMD_START) ? 2'd0 : 2'd3;
            end
            OP_RT_GATE:   gate_ff <= gate_new;
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign status.cmd          = lat_cmd_ff;
   assign status.ended        = ended_ff;
   assign status.resync_busy  = (resync_ff != 2'd0);
   assign status.paused       = paused_ff;
   assign status.empty        = empty_ff;
   assign status.pos_last     = (pos_ff == POS_LAST);
   assign status.step_due     = step_due;
   assign status.knob_changed = (knob_new != target_ff);
   assign status.out_free     = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

// ===== tb/sv/bdc_result_checker.sv =====
// Result checker of the battery discharge controller testbench.
// Watches the request, response and configuration ports, models the controller
// and compares each response with its prediction. Depends on bdc_pkg and bdc_if.
`default_nettype none

module bdc_result_checker
   import bdc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   bdc_req_if                          req_bus,
   bdc_rsp_if                          rsp_bus,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic [31:0]                 error_count,
   output logic [31:0]                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AVG_SAMPLES     = 8;
   localparam int REFRESH_SECONDS = 5;
   localparam int PRINT_LIMIT     = 40;

   typedef struct packed {
      logic [11:0] gate_code;
      logic        is_paused;
      logic [1:0]  current_range;
      logic        finished;
      logic [1:0]  end_cause;
      logic [13:0] avg_voltage_mv;
      logic [11:0] avg_current_ma;
      logic [31:0] charge_sum;
      logic [11:0] setpoint_ma;
   } bdc_result_t;

   // configuration copy
   logic [9:0]  cfg_wire_res;
   logic [12:0] cfg_min_mv;
   logic [10:0] cfg_init_target;
   logic [11:0] cfg_oc_limit;
   logic [11:0] cfg_power_cap;

   // controller state copy
   logic [11:0] cur_win [AVG_SAMPLES];
   logic [12:0] volt_win [AVG_SAMPLES];
   int unsigned win_pos;
   logic        win_empty;
   logic [10:0] target;
   logic [11:0] setpoint;
   logic [11:0] gate;
   logic [1:0]  range;
   logic        paused;
   logic        ended;
   logic [1:0]  resync;
   logic [31:0] charge;
   logic [1:0]  cause;

   bdc_result_t predicted_results [$];
   int unsigned mismatches;
   int unsigned result_index;

   task automatic report(input string msg);
      if (mismatches < PRINT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want)
         report($sformatf("response %0d %s: expected %0d, got %0d",
                          result_index, name, want, got));
   endtask

   function automatic logic [11:0] gate_for(input logic [11:0] amps);
      int unsigned a;
      int unsigned v;
      a = amps;
      if (a < 200) v = 2 * a + 1440;
      else if (a < 1100) v = 1525 + (128 * a) / 100;
      else v = 1443 + (138 * a) / 100;
      if (v > 4095) v = 4095;
      return v[11:0];
   endfunction

   task automatic retarget();
      win_empty = 1'b1;
      if (cfg_power_cap < 12'(target)) setpoint = 12'(50 + 100 * (cfg_power_cap / 100));
      else setpoint = 12'(target);
      gate   = gate_for(setpoint);
      resync = 2'd3;
   endtask

   task automatic take_sample(input logic [12:0] mv, input logic [11:0] ma, input logic rf,
                              output int unsigned av, output int unsigned aa);
      int unsigned     sv;
      int unsigned     sa;
      int unsigned     limit;
      longint unsigned total;
      sv = 0;
      sa = 0;
      if (win_empty) begin
         for (int i = 0; i < AVG_SAMPLES; i++) begin
            cur_win[i]  = ma;
            volt_win[i] = mv;
         end
         win_pos   = 0;
         win_empty = 1'b0;
      end
      cur_win[win_pos]  = ma;
      volt_win[win_pos] = mv;
      win_pos = (win_pos + 1) % AVG_SAMPLES;
      for (int i = 0; i < AVG_SAMPLES; i++) begin
         sa += cur_win[i];
         sv += volt_win[i];
      end
      aa = sa / AVG_SAMPLES;
      av = sv / AVG_SAMPLES + (aa * cfg_wire_res) / 1000;

      // range step-down skips the end checks and the charge update
      if (range == RANGE_HIGH) begin
         limit = (setpoint > 700) ? 3100 : 3300;
         if (av < limit && setpoint > 500) begin
            target = 11'd500;
            retarget();
            range = RANGE_MEDIUM;
            return;
         end
      end else if (range == RANGE_MEDIUM) begin
         if (av < 3200 && setpoint > 250) begin
            target = 11'd250;
            retarget();
            range = RANGE_LOW;
            return;
         end
      end
      if (av < cfg_min_mv) begin
         ended = 1'b1;
         cause = CAUSE_VOLTAGE;
         return;
      end
      if (ma > cfg_oc_limit) begin
         ended = 1'b1;
         cause = CAUSE_CURRENT;
         return;
      end
      if (rf) begin
         total  = longint'(charge) + longint'(REFRESH_SECONDS) * longint'(aa);
         charge = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
      end
   endtask

   task automatic advance_controller(input bdc_cmd_type cmd, input logic [12:0] mv,
                                     input logic [11:0] ma, input logic rf,
                                     input logic signed [1:0] kd, output bdc_result_t res);
      int unsigned av;
      int unsigned aa;
      int unsigned knob_target;
      av = 0;
      aa = 0;
      if (cmd == CMD_START) begin
         charge = '0;
         paused = 1'b0;
         ended  = 1'b0;
         cause  = CAUSE_NONE;
         target = cfg_init_target;
         retarget();
         resync    = 2'd0;
         range     = RANGE_HIGH;
         win_empty = 1'b1;
      end else if (!ended) begin
         case (cmd)
            CMD_SAMPLE: begin
               if (resync != 0) resync--;
               else if (!paused) take_sample(mv, ma, rf, av, aa);
            end
            CMD_PAUSE: begin
               paused = !paused;
               if (!paused) retarget();
            end
            CMD_KNOB: begin
               if (kd != 0) begin
                  knob_target = target;
                  if (knob_target < 1500 && kd > 0) knob_target += 100;
                  if (knob_target > 150 && kd < 0) knob_target -= 100;
                  if (knob_target != target) begin
                     target = 11'(knob_target);
                     retarget();
                  end
               end
            end
            default: ;
         endcase
      end
      res.gate_code      = (paused || ended) ? 12'd0 : gate;
      res.is_paused      = paused;
      res.current_range  = range;
      res.finished       = ended;
      res.end_cause      = cause;
      res.avg_voltage_mv = 14'(av);
      res.avg_current_ma = 12'(aa);
      res.charge_sum     = charge;
      res.setpoint_ma    = setpoint;
   endtask

   always @(posedge clock) begin : watch
      bdc_result_t want;
      bdc_result_t seen;
      if (reset) begin
         cfg_wire_res    = 10'd0;
         cfg_min_mv      = 13'd3000;
         cfg_init_target = 11'd500;
         cfg_oc_limit    = 12'd2000;
         cfg_power_cap   = 12'd4000;
         win_pos   = 0;
         win_empty = 1'b1;
         target    = '0;
         setpoint  = '0;
         gate      = '0;
         range     = RANGE_HIGH;
         paused    = 1'b0;
         ended     = 1'b0;
         resync    = 2'd0;
         charge    = '0;
         cause     = CAUSE_NONE;
         predicted_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WIRE_RES:    cfg_wire_res    = csr_wdata[9:0];
               CSR_MIN_VOLTAGE: cfg_min_mv      = csr_wdata[12:0];
               CSR_INIT_TARGET: cfg_init_target = csr_wdata[10:0];
               CSR_OVERCURRENT: cfg_oc_limit    = csr_wdata[11:0];
               CSR_POWER_CAP:   cfg_power_cap   = csr_wdata[11:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            advance_controller(bdc_cmd_type'(req_bus.cmd), req_bus.voltage_mv,
                               req_bus.current_ma, req_bus.refresh_due,
                               req_bus.knob_direction, want);
            predicted_results.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.gate_code      = rsp_bus.gate_code;
            seen.is_paused      = rsp_bus.is_paused;
            seen.current_range  = rsp_bus.current_range;
            seen.finished       = rsp_bus.finished;
            seen.end_cause      = rsp_bus.end_cause;
            seen.avg_voltage_mv = rsp_bus.avg_voltage_mv;
            seen.avg_current_ma = rsp_bus.avg_current_ma;
            seen.charge_sum     = rsp_bus.charge_sum;
            seen.setpoint_ma    = rsp_bus.setpoint_ma;
            if (predicted_results.size() == 0) begin
               report($sformatf("response %0d arrived with no request outstanding",
                                result_index));
            end else begin
               want = predicted_results.pop_front();
               check_field("gate_code", 32'(want.gate_code), 32'(seen.gate_code));
               check_field("is_paused", 32'(want.is_paused), 32'(seen.is_paused));
               check_field("current_range", 32'(want.current_range),
                           32'(seen.current_range));
               check_field("finished", 32'(want.finished), 32'(seen.finished));
               check_field("end_cause", 32'(want.end_cause), 32'(seen.end_cause));
               check_field("avg_voltage_mv", 32'(want.avg_voltage_mv),
                           32'(seen.avg_voltage_mv));
               check_field("avg_current_ma", 32'(want.avg_current_ma),
                           32'(seen.avg_current_ma));
               check_field("charge_sum", want.charge_sum, seen.charge_sum);
               check_field("setpoint_ma", 32'(want.setpoint_ma), 32'(seen.setpoint_ma));
            end
            result_index++;
         end
      end
      pending_count <= predicted_results.size();
      error_count   <= mismatches;
   end

   initial begin
      mismatches    = 0;
      result_index  = 0;
      error_count   = '0;
      pending_count = '0;
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Top of the battery discharge controller testbench: clock, reset, stimulus.
// Drives requests, configuration and response backpressure; the verdict comes
// from bdc_result_checker. Depends on bdc_pkg, bdc_if and the controller.
`default_nettype none

module tb;
   import bdc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000; // far above the slowest correct run
   localparam int IDLE_CYCLES  = 40;     // beyond the slowest request latency
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 115;
   localparam int HOLD_AFTER   = 200;    // responses taken before the long stall
   localparam int HOLD_CYCLES  = 300;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic [31:0]            error_count;
   logic [31:0]            pending_count;

   bdc_req_if req_bus ();
   bdc_rsp_if rsp_bus ();

   battery_discharge_controller #(
      .AVG_SAMPLES     (8),
      .REFRESH_SECONDS (5)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bdc_result_checker checker_u (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Stimulus-side knowledge of the configuration, used only to steer the
   // battery voltage and current around the thresholds in effect.
   int cfg_min;
   int cfg_oc;
   int burst_left;
   int items_sent;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stop a hung run: count cycles and give up at the limit.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Offer one request and hold it until the handshake completes. The sender
   // works in bursts; at the start of each burst it may drop valid for a
   // random gap. Valid is never lowered and raised in the same step.
   task automatic send_req(input bdc_cmd_type cmd, input logic [12:0] mv,
                           input logic [11:0] ma, input logic rf,
                           input logic signed [1:0] kd);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid          <= 1'b1;
      req_bus.cmd            <= cmd;
      req_bus.voltage_mv     <= mv;
      req_bus.current_ma     <= ma;
      req_bus.refresh_due    <= rf;
      req_bus.knob_direction <= kd;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid, wait until every predicted response has come back, then let
   // the block settle before anything touches the configuration.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_INDEX_W-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   // Write all five registers back to back; hold the write enable across them.
   task automatic load_config(input int wire_res, input int min_mv, input int init_ma,
                              input int oc_ma, input int cap_ma);
      cfg_min = min_mv;
      cfg_oc  = oc_ma;
      csr_put(CSR_WIRE_RES, wire_res);
      csr_put(CSR_MIN_VOLTAGE, min_mv);
      csr_put(CSR_INIT_TARGET, init_ma);
      csr_put(CSR_OVERCURRENT, oc_ma);
      csr_put(CSR_POWER_CAP, cap_ma);
      csr_we <= 1'b0;
   endtask

   task automatic send_noise();
      send_req(bdc_cmd_type'(2'($urandom)), 13'($urandom), 12'($urandom),
               1'($urandom), 2'($urandom));
   endtask

   // One discharge test: start, then a battery whose voltage sags from above
   // the end threshold, with currents under the limit, occasional overcurrent
   // spikes, pause toggles and knob turns mixed in. Stop once the test has
   // surely ended so that few requests land on a finished controller.
   task automatic discharge_episode();
      int          steps;
      int          v;
      int          r;
      int          tail;
      int          top;
      logic [11:0] ma;
      steps = $urandom_range(15, 60);
      v = cfg_min + $urandom_range(50, 1200);
      if (v > 8191) v = 8191;
      tail = -1;
      send_req(CMD_START, 13'($urandom), 12'($urandom), 1'($urandom), 2'($urandom));
      for (int s = 0; s < steps; s++) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            send_req(CMD_PAUSE, 13'($urandom), 12'($urandom), 1'($urandom), 2'($urandom));
         end else if (r < 14) begin
            send_req(CMD_KNOB, 13'($urandom), 12'($urandom), 1'($urandom), 2'($urandom));
         end else begin
            top = (cfg_oc < 1700) ? cfg_oc : 1700;
            ma = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(0, top));
            if ($urandom_range(0, 39) == 0) begin
               // overcurrent spike, end the test shortly after
               ma = (cfg_oc + 400 > 4095) ? 12'd4095 : 12'(cfg_oc + $urandom_range(1, 400));
               tail = $urandom_range(0, 2);
            end
            send_req(CMD_SAMPLE, 13'(v), ma, ($urandom_range(0, 9) < 3), 2'($urandom));
            v -= $urandom_range(0, 40);
            if (v < 0) v = 0;
         end
         if (tail == 0) break;
         if (tail > 0) tail--;
         if (v + 200 < cfg_min) break;
      end
   endtask

   // Receiver: change the backpressure pattern at random intervals, and
   // once, mid-run, refuse responses for a long stretch so the block fills
   // and stalls its requests.
   initial begin : rsp_sink
      int mode;
      int span;
      int taken;
      bit held;
      rsp_bus.ready <= 1'b0;
      mode  = 0;
      span  = 0;
      taken = 0;
      held  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) taken++;
         if (!held && taken == HOLD_AFTER) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 2);
               span = $urandom_range(8, 80);
            end
            span--;
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      int wire_res;
      int min_mv;
      int init_ma;
      int oc_ma;
      int cap_ma;
      int phase_end;
      req_bus.valid          <= 1'b0;
      req_bus.cmd            <= CMD_START;
      req_bus.voltage_mv     <= '0;
      req_bus.current_ma     <= '0;
      req_bus.refresh_due    <= 1'b0;
      req_bus.knob_direction <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_WIRE_RES;
      csr_wdata <= '0;
      burst_left = 0;
      items_sent = 0;
      cfg_min = 3000;
      cfg_oc  = 2000;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: target 1000 so the high range steps at 3100 mV.
      load_config(100, 3000, 1000, 2000, 4000);
      // sample before any start
      send_req(CMD_SAMPLE, 13'd8191, 12'd0, 1'b1, 2'sd0);
      send_req(CMD_START, 13'd0, 12'd0, 1'b0, 2'sd0);
      // first sample fills the window; raw current above the limit ends the test
      send_req(CMD_SAMPLE, 13'd8191, 12'd4095, 1'b1, -2'sd1);
      // finished: everything but start is ignored
      send_req(CMD_SAMPLE, 13'd5000, 12'd100, 1'b1, 2'sd0);
      send_req(CMD_KNOB, 13'd0, 12'd0, 1'b0, 2'sd1);
      send_req(CMD_START, 13'd0, 12'd0, 1'b0, 2'sd0);
      send_req(CMD_SAMPLE, 13'd4000, 12'd1000, 1'b1, 2'sd0);
      // knob with no direction, then a raise that retargets into resync
      send_req(CMD_KNOB, 13'd0, 12'd0, 1'b0, 2'sd0);
      send_req(CMD_KNOB, 13'd0, 12'd0, 1'b0, 2'sd1);
      for (int i = 0; i < 3; i++)
         send_req(CMD_SAMPLE, 13'($urandom), 12'($urandom), 1'b1, 2'sd0);
      // pause, lower by a direction of -2 while paused, unpause
      send_req(CMD_PAUSE, 13'd0, 12'd0, 1'b0, 2'sd0);
      send_req(CMD_KNOB, 13'd0, 12'd0, 1'b0, -2'sd2);
      send_req(CMD_PAUSE, 13'd0, 12'd0, 1'b0, 2'sd0);
      for (int i = 0; i < 3; i++)
         send_req(CMD_SAMPLE, 13'd0, 12'd0, 1'b0, 2'sd0);
      // sag below 3100 mV: step to the medium range
      send_req(CMD_SAMPLE, 13'd2900, 12'd100, 1'b1, 2'sd0);
      for (int i = 0; i < 3; i++)
         send_req(CMD_SAMPLE, 13'd4000, 12'd0, 1'b0, 2'sd0);
      // below 3200 mV in medium: step to the low range
      send_req(CMD_SAMPLE, 13'd3100, 12'd100, 1'b1, 2'sd0);
      for (int i = 0; i < 3; i++)
         send_req(CMD_SAMPLE, 13'd4000, 12'd0, 1'b0, 2'sd0);
      // below the minimum voltage: end of test
      send_req(CMD_SAMPLE, 13'd2000, 12'd0, 1'b1, 2'sd0);
      wait_idle();

      // Random part: registers at zero, then at top tested values, then random
      // settings. Pause the sender until all responses are in between phases.
      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            wire_res = 0; min_mv = 0; init_ma = 0; oc_ma = 0; cap_ma = 0;
         end else if (p == 1) begin
            wire_res = 1000; min_mv = 8191; init_ma = 1600; oc_ma = 4095; cap_ma = 4095;
         end else begin
            wire_res = $urandom_range(0, 1000);
            min_mv   = $urandom_range(2400, 3400);
            init_ma  = $urandom_range(0, 1600);
            oc_ma    = $urandom_range(1200, 4095);
            cap_ma   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1600)
                                                   : $urandom_range(1600, 4095);
         end
         load_config(wire_res, min_mv, init_ma, oc_ma, cap_ma);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 99) < 85) begin
               discharge_episode();
            end else begin
               repeat ($urandom_range(1, 8)) send_noise();
            end
         end
         wait_idle();
      end

      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== battery_discharge_controller.f =====
rtl/bdc_pkg.sv
rtl/bdc_if.sv
rtl/bdc_ctrl.sv
rtl/bdc_dp.sv
rtl/battery_discharge_controller.sv
tb/sv/bdc_result_checker.sv
tb/sv/tb.sv
